### sv/fire_heat_stencil_defines.svh
// Assertion macros for the fire heat stencil checker.
// No dependencies; included by the checker file.
`ifndef FIRE_HEAT_STENCIL_DEFINES_SVH
`define FIRE_HEAT_STENCIL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fhs_pkg.sv
// Shared constants for the fire heat stencil: sizes, register indexes,
// reset values and the reciprocal constants of the two scaling modes.
// No dependencies.
package fhs_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int HEAT_W = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);        // column index
    localparam int ROW_W  = $clog2(MAX_HEIGHT);       // row index
    localparam int EW_W   = $clog2(MAX_WIDTH + 1);    // effective width
    localparam int EH_W   = $clog2(MAX_HEIGHT + 1);   // effective height

    localparam int NUM_SLOTS = 4;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);

    // configuration register file
    localparam int CFG_MODE_W   = 1;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FIRE_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [CFG_WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd320;
    localparam logic [CFG_HEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd200;

    // four-tap sum and scaling datapath
    localparam int SUM_W    = HEAT_W + 2;
    localparam int SCALE_0  = 5;                      // x32
    localparam int SCALE_1  = 6;                      // x64
    localparam int SCALED_W = SUM_W + SCALE_1;
    localparam int RECIP_W  = 17;
    localparam int PROD_W   = SCALED_W + RECIP_W;

    // floor(x / 129) = (x * RECIP_0) >> SHIFT_0 for x <= 32640
    localparam logic [RECIP_W-1:0] RECIP_0 = 17'd32514;
    localparam int                 SHIFT_0 = 22;
    // floor(x / 257) = (x * RECIP_1) >> SHIFT_1 for x <= 65280
    localparam logic [RECIP_W-1:0] RECIP_1 = 17'd65281;
    localparam int                 SHIFT_1 = 24;

endpackage

### sv/fhs_if.sv
// Valid/ready stream interfaces for the fire heat stencil pixel channels.
// Depends on fhs_pkg for the heat width.
interface fhs_in_if;
    logic                        valid;
    logic                        ready;
    logic [fhs_pkg::HEAT_W-1:0]  heat_in;

    modport source (output valid, output heat_in, input ready);
    modport sink   (input valid, input heat_in, output ready);
endinterface

interface fhs_out_if;
    logic                        valid;
    logic                        ready;
    logic [fhs_pkg::HEAT_W-1:0]  heat_out;
    logic                        frame_end;

    modport source (output valid, output heat_out, output frame_end, input ready);
    modport sink   (input valid, input heat_out, input frame_end, output ready);
endinterface

### sv/fhs_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module fhs_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### sv/fire_heat_stencil.sv
// Fire heat stencil: one step of the fire effect over a pixel stream.
// Depends on fhs_pkg, fhs_if (fhs_in_if, fhs_out_if) and fhs_ram.
//
// Pixels of the old heat map enter bottom row first, each row left to right,
// and the new heat of the same position leaves in the same order. The block
// takes one pixel per clock while the output is not stalled, and a pixel's
// result reaches the output register through four register stages (line
// store read, loaded at the accepting edge, then tap select and sum,
// reciprocal multiply, shift and output). A stalled output freezes the
// whole pipeline, so in_ready follows the output side. Four line stores of
// MAX_WIDTH bytes, one RAM each with one write and two read ports, hold the
// rows below; no clearing pass is needed after reset. Any configuration
// write to a known register restarts the frame at the bottom-left pixel.
module fire_heat_stencil (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fhs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fhs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    fhs_in_if.sink                            i_pix,
    fhs_out_if.source                         o_pix
);

    typedef struct packed {
        logic                         first;   // bottom row: pass through
        logic                         left;    // left neighbor present
        logic                         right;   // right neighbor present
        logic                         has2;    // two rows below present
        logic                         has3;    // three rows below present
        logic                         fend;    // last pixel of the frame
        logic [fhs_pkg::SLOT_W-1:0]   rot;     // slot of this pixel's row
    } t_s1_info;

    // ---------------- configuration ----------------
    logic                              r_mode;
    logic [fhs_pkg::CFG_WIDTH_W-1:0]   r_fw;
    logic [fhs_pkg::CFG_HEIGHT_W-1:0]  r_fh;
    logic                              cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_idx == fhs_pkg::REG_FIRE_MODE ||
                                  i_cfg_idx == fhs_pkg::REG_FRAME_WIDTH ||
                                  i_cfg_idx == fhs_pkg::REG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_fw   <= fhs_pkg::RST_FRAME_WIDTH;
            r_fh   <= fhs_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fhs_pkg::REG_FIRE_MODE:    r_mode <= i_cfg_data[0];
                fhs_pkg::REG_FRAME_WIDTH:  r_fw   <= i_cfg_data[fhs_pkg::CFG_WIDTH_W-1:0];
                fhs_pkg::REG_FRAME_HEIGHT: r_fh   <= i_cfg_data[fhs_pkg::CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    logic [fhs_pkg::EW_W-1:0] eff_w;
    logic [fhs_pkg::EH_W-1:0] eff_h;

    always_comb begin
        if (r_fw == '0) begin
            eff_w = fhs_pkg::EW_W'(1);
        end else if (32'(r_fw) > fhs_pkg::MAX_WIDTH) begin
            eff_w = fhs_pkg::EW_W'(fhs_pkg::MAX_WIDTH);
        end else begin
            eff_w = fhs_pkg::EW_W'(r_fw);
        end
        if (r_fh == '0) begin
            eff_h = fhs_pkg::EH_W'(1);
        end else if (32'(r_fh) > fhs_pkg::MAX_HEIGHT) begin
            eff_h = fhs_pkg::EH_W'(fhs_pkg::MAX_HEIGHT);
        end else begin
            eff_h = fhs_pkg::EH_W'(r_fh);
        end
    end

    // ---------------- handshake ----------------
    logic r_v1, r_v2, r_v3, r_vo;
    logic en;
    logic acc;

    assign en          = !r_vo || o_pix.ready;
    assign i_pix.ready = en;
    assign acc         = i_pix.valid && en;

    // ---------------- position counters ----------------
    logic [fhs_pkg::COL_W-1:0]  r_col;
    logic [fhs_pkg::ROW_W-1:0]  r_row;
    logic [fhs_pkg::SLOT_W-1:0] r_rot;
    logic                       last_col;
    logic                       last_row;
    logic                       frame_end;

    assign last_col  = (fhs_pkg::EW_W'(r_col) + fhs_pkg::EW_W'(1)) == eff_w;
    assign last_row  = (fhs_pkg::EH_W'(r_row) + fhs_pkg::EH_W'(1)) == eff_h;
    assign frame_end = last_col && last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
            r_rot <= '0;
        end else if (acc) begin
            if (frame_end) begin
                r_col <= '0;
                r_row <= '0;
                r_rot <= '0;
            end else if (last_col) begin
                r_col <= '0;
                r_row <= r_row + fhs_pkg::ROW_W'(1);
                r_rot <= r_rot + fhs_pkg::SLOT_W'(1);
            end else begin
                r_col <= r_col + fhs_pkg::COL_W'(1);
            end
        end
    end

    // ---------------- line stores ----------------
    logic [fhs_pkg::HEAT_W-1:0] rd_a [fhs_pkg::NUM_SLOTS];
    logic [fhs_pkg::HEAT_W-1:0] rd_b [fhs_pkg::NUM_SLOTS];
    logic [fhs_pkg::COL_W-1:0]  col_next;

    // past the row end this reads a don't-care entry; the right tap is muxed off
    assign col_next = r_col + fhs_pkg::COL_W'(1);

    for (genvar g = 0; g < fhs_pkg::NUM_SLOTS; g++) begin : g_line
        fhs_ram #(
            .WIDTH (fhs_pkg::HEAT_W),
            .DEPTH (fhs_pkg::MAX_WIDTH)
        ) u_line (
            .i_clk     (i_clk),
            .i_we      (acc && (r_rot == fhs_pkg::SLOT_W'(g))),
            .i_waddr   (r_col),
            .i_wdata   (i_pix.heat_in),
            .i_re      (acc),
            .i_raddr_a (r_col),
            .i_raddr_b (col_next),
            .o_rdata_a (rd_a[g]),
            .o_rdata_b (rd_b[g])
        );
    end

    // ---------------- stage 1: taps and sum ----------------
    t_s1_info                   r_s1;
    t_s1_info                   n_s1;
    logic [fhs_pkg::HEAT_W-1:0] r_s1_heat;
    logic [fhs_pkg::HEAT_W-1:0] r_prev_c1;   // center tap of the previous pixel
    logic [fhs_pkg::SLOT_W-1:0] slot1, slot2, slot3;
    logic [fhs_pkg::HEAT_W-1:0] c1, l1, r1, c2, c3;
    logic [fhs_pkg::SUM_W-1:0]  n_sum;

    always_comb begin
        n_s1.first = (r_row == '0);
        n_s1.left  = (r_col != '0);
        n_s1.right = !last_col;
        n_s1.has2  = 32'(r_row) >= 32'd2;
        n_s1.has3  = 32'(r_row) >= 32'd3;
        n_s1.fend  = frame_end;
        n_s1.rot   = r_rot;
    end

    assign slot1 = r_s1.rot - fhs_pkg::SLOT_W'(1);
    assign slot2 = r_s1.rot - fhs_pkg::SLOT_W'(2);
    assign slot3 = r_s1.rot - fhs_pkg::SLOT_W'(3);

    always_comb begin
        c1 = rd_a[slot1];
        l1 = r_s1.left  ? r_prev_c1    : c1;
        r1 = r_s1.right ? rd_b[slot1]  : c1;
        c2 = r_s1.has2  ? rd_a[slot2]  : c1;
        c3 = r_s1.has3  ? rd_a[slot3]  : c2;
        if (r_mode) begin
            n_sum = fhs_pkg::SUM_W'(l1) + fhs_pkg::SUM_W'(r1) +
                    fhs_pkg::SUM_W'(c2) + fhs_pkg::SUM_W'(c3);
        end else begin
            n_sum = fhs_pkg::SUM_W'(l1) + fhs_pkg::SUM_W'(c1) +
                    fhs_pkg::SUM_W'(r1) + fhs_pkg::SUM_W'(c2);
        end
    end

    // ---------------- stage 2: reciprocal multiply ----------------
    logic [fhs_pkg::SUM_W-1:0]    r_s2_sum;
    logic                         r_s2_pass;
    logic                         r_s2_fend;
    logic [fhs_pkg::HEAT_W-1:0]   r_s2_heat;
    logic [fhs_pkg::SCALED_W-1:0] scaled;
    logic [fhs_pkg::PROD_W-1:0]   n_prod;

    always_comb begin
        if (r_mode) begin
            scaled = fhs_pkg::SCALED_W'(r_s2_sum) << fhs_pkg::SCALE_1;
            n_prod = fhs_pkg::PROD_W'(scaled) * fhs_pkg::PROD_W'(fhs_pkg::RECIP_1);
        end else begin
            scaled = fhs_pkg::SCALED_W'(r_s2_sum) << fhs_pkg::SCALE_0;
            n_prod = fhs_pkg::PROD_W'(scaled) * fhs_pkg::PROD_W'(fhs_pkg::RECIP_0);
        end
    end

    // ---------------- stage 3: shift and select ----------------
    logic [fhs_pkg::PROD_W-1:0] r_s3_prod;
    logic                       r_s3_pass;
    logic                       r_s3_fend;
    logic [fhs_pkg::HEAT_W-1:0] r_s3_heat;
    logic [fhs_pkg::PROD_W-1:0] quot;
    logic [fhs_pkg::HEAT_W-1:0] n_heat_out;

    always_comb begin
        quot       = r_mode ? (r_s3_prod >> fhs_pkg::SHIFT_1)
                            : (r_s3_prod >> fhs_pkg::SHIFT_0);
        n_heat_out = r_s3_pass ? r_s3_heat : quot[fhs_pkg::HEAT_W-1:0];
    end

    logic [fhs_pkg::HEAT_W-1:0] r_heat_out;
    logic                       r_frame_end;

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (acc) begin
                r_s1      <= n_s1;
                r_s1_heat <= i_pix.heat_in;
            end
            if (r_v1) begin
                r_prev_c1 <= c1;
            end
            r_s2_sum    <= n_sum;
            r_s2_pass   <= r_s1.first;
            r_s2_fend   <= r_s1.fend;
            r_s2_heat   <= r_s1_heat;
            r_s3_prod   <= n_prod;
            r_s3_pass   <= r_s2_pass;
            r_s3_fend   <= r_s2_fend;
            r_s3_heat   <= r_s2_heat;
            r_heat_out  <= n_heat_out;
            r_frame_end <= r_s3_fend;
        end
    end

    assign o_pix.valid     = r_vo;
    assign o_pix.heat_out  = r_heat_out;
    assign o_pix.frame_end = r_frame_end;

endmodule

### sv/fhs_checker.sv
// Port-level checker for fire_heat_stencil, attached by bind below.
// Depends on fhs_pkg and fire_heat_stencil_defines.svh.
`include "fire_heat_stencil_defines.svh"

module fhs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [fhs_pkg::HEAT_W-1:0]  i_heat_out,
    input logic                        i_frame_end
);

    // the input side only waits on a blocked output transaction
    `FHS_ASSERT_IMP(a_ready_follows_out, i_clk, i_rst_n, 1'b1, i_in_ready == (!i_out_valid || i_out_ready), "in ready does not follow output side")

    // an accepted pixel reaches the output if the output stays ready while it passes the pipeline stages
    `FHS_ASSERT_NXT(a_latency, i_clk, i_rst_n, (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready, i_out_valid, "accepted pixel did not reach the output")

    // a stalled result holds
    `FHS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_heat_out) && $stable(i_frame_end), "stalled output changed")

endmodule

bind fire_heat_stencil fhs_checker u_fhs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_heat_out  (o_pix.heat_out),
    .i_frame_end (o_pix.frame_end)
);
